FILE: design/generational_handle_table_core_macros.svh
`ifndef GENERATIONAL_HANDLE_TABLE_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define GHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

    localparam int DOMAINS_DEF    = 8;
    localparam int SLOTS_DEF      = 256;
    localparam int INDEX_BITS_DEF = 24;
    localparam int GEN_W          = 8;
    localparam int COUNT_W        = 8;
    localparam int DOMAIN_W       = 4;
    localparam int REQ_W          = 2;
    localparam int WORD_W         = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_GET     = 2'd1,
        REQ_TAKE    = 2'd2,
        REQ_REPLACE = 2'd3
    } ght_req_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ght_state_t;

    typedef struct packed {
        logic issue;
        logic commit;
    } ght_cmd_t;

    function automatic logic [COUNT_W-1:0] sat_count(input logic [31:0] v);
        return (v > 32'd255) ? 8'hFF : v[COUNT_W-1:0];
    endfunction

endpackage

FILE: design/ght_ctrl.sv
`timescale 1ns / 1ps

module ght_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ght_pkg::ght_cmd_t cmd
);
    import ght_pkg::*;

    ght_state_t state_reg;
    ght_state_t state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.issue  = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.issue = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.commit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: design/ght_dp.sv
`timescale 1ns / 1ps

module ght_dp
#(
    parameter int DOMAINS    = ght_pkg::DOMAINS_DEF,
    parameter int SLOTS      = ght_pkg::SLOTS_DEF,
    parameter int INDEX_BITS = ght_pkg::INDEX_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ght_pkg::ght_cmd_t             cmd,
    input  logic [ght_pkg::REQ_W-1:0]     req_type,
    input  logic [ght_pkg::DOMAIN_W-1:0]  domain,
    input  logic [ght_pkg::WORD_W-1:0]    handle,
    input  logic [ght_pkg::WORD_W-1:0]    object,
    output logic                          ok,
    output logic [ght_pkg::WORD_W-1:0]    out_handle,
    output logic [ght_pkg::WORD_W-1:0]    out_object,
    output logic [ght_pkg::COUNT_W-1:0]   live_count,
    output logic [ght_pkg::COUNT_W-1:0]   peak_count
);
    import ght_pkg::*;

    localparam int IW    = $clog2(SLOTS);
    localparam int DW    = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
    localparam int DEPTH = DOMAINS * SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW:0] SLOTS_A = (AW+1)'(SLOTS);
    localparam logic [IW:0] SLOTS_I = (IW+1)'(SLOTS);

    function automatic logic [AW-1:0] slot_addr(input logic [DW-1:0] d,
                                                 input logic [IW-1:0] i);
        logic [AW:0] t;
        t = (AW+1)'(d) * SLOTS_A + (AW+1)'(i);
        return t[AW-1:0];
    endfunction

    // slot stores
    logic [WORD_W-1:0] obj_mem  [DEPTH];
    logic [GEN_W-1:0]  gen_mem  [DEPTH];
    logic [IW-1:0]     next_mem [DEPTH];

    logic [WORD_W-1:0] rd_obj_reg;
    logic [GEN_W-1:0]  rd_gen_reg;
    logic [IW-1:0]     rd_next_reg;

    // per-domain state; fill marks the first slot never handed out
    logic [IW-1:0] head_reg [DOMAINS];
    logic [IW-1:0] head_next [DOMAINS];
    logic [IW:0]   fill_reg [DOMAINS];
    logic [IW:0]   fill_next [DOMAINS];
    logic [IW-1:0] live_reg [DOMAINS];
    logic [IW-1:0] live_next [DOMAINS];
    logic [IW-1:0] peak_reg [DOMAINS];
    logic [IW-1:0] peak_next [DOMAINS];

    // latched request
    ght_req_t          req_reg;
    logic              dom_ok_reg;
    logic [DW-1:0]     dom_reg;
    logic [IW-1:0]     idx_reg;
    logic              idx_ok_reg;
    logic [GEN_W-1:0]  hgen_reg;
    logic [WORD_W-1:0] obj_reg;
    logic [AW-1:0]     addr_reg;

    // output payload
    logic              ok_reg;
    logic [WORD_W-1:0] out_handle_reg;
    logic [WORD_W-1:0] out_object_reg;
    logic [COUNT_W-1:0] live_count_reg;
    logic [COUNT_W-1:0] peak_count_reg;

    logic                  in_dom_ok;
    logic [DW-1:0]         in_dom;
    logic [INDEX_BITS-1:0] in_idx_full;
    logic                  in_idx_ok;
    logic [IW-1:0]         in_idx;
    logic [AW-1:0]         rd_addr;

    assign in_dom_ok   = ({1'b0, domain} < (DOMAIN_W+1)'(DOMAINS));
    assign in_dom      = in_dom_ok ? domain[DW-1:0] : '0;
    assign in_idx_full = handle[INDEX_BITS-1:0];
    assign in_idx_ok   = (in_idx_full != '0) &&
                         ((INDEX_BITS+1)'(in_idx_full) < (INDEX_BITS+1)'(SLOTS));
    assign in_idx      = in_idx_ok ? in_idx_full[IW-1:0] : '0;

    always_comb
    begin
        if (!in_dom_ok)
        begin
            rd_addr = '0;
        end
        else if (ght_req_t'(req_type) == REQ_ALLOC)
        begin
            rd_addr = slot_addr(in_dom, head_reg[in_dom]);
        end
        else
        begin
            rd_addr = slot_addr(in_dom, in_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            req_reg    <= ght_req_t'(req_type);
            dom_ok_reg <= in_dom_ok;
            dom_reg    <= in_dom;
            idx_reg    <= in_idx;
            idx_ok_reg <= in_idx_ok;
            hgen_reg   <= handle[INDEX_BITS +: GEN_W];
            obj_reg    <= object;
            addr_reg   <= rd_addr;
        end
    end

    // execute stage
    logic [IW-1:0]     head_cur;
    logic [IW:0]       fill_cur;
    logic [IW-1:0]     live_cur;
    logic [IW-1:0]     peak_cur;
    logic              fresh;
    logic [IW:0]       head_inc;
    logic [IW-1:0]     fresh_next;
    logic              slot_ok;
    logic              succ;
    logic [GEN_W-1:0]  alloc_gen;
    logic [IW-1:0]     live_new;
    logic [WORD_W-1:0] res_handle;
    logic [WORD_W-1:0] res_object;
    logic              obj_we;
    logic [WORD_W-1:0] obj_wd;
    logic              gen_we;
    logic [GEN_W-1:0]  gen_wd;
    logic              next_we;
    logic [IW-1:0]     next_wd;

    always_comb
    begin
        head_cur   = head_reg[dom_reg];
        fill_cur   = fill_reg[dom_reg];
        live_cur   = live_reg[dom_reg];
        peak_cur   = peak_reg[dom_reg];
        fresh      = ({1'b0, head_cur} >= fill_cur);
        head_inc   = {1'b0, head_cur} + 1'b1;
        fresh_next = (head_inc < SLOTS_I) ? head_inc[IW-1:0] : '0;
        slot_ok    = idx_ok_reg && ({1'b0, idx_reg} < fill_cur) &&
                     (rd_obj_reg != '0) && (rd_gen_reg == hgen_reg);
        alloc_gen  = fresh ? '0 : rd_gen_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        live_next  = live_reg;
        peak_next  = peak_reg;
        live_new   = live_cur;
        succ       = 1'b0;
        res_handle = '0;
        res_object = '0;
        obj_we     = 1'b0;
        obj_wd     = obj_reg;
        gen_we     = 1'b0;
        gen_wd     = '0;
        next_we    = 1'b0;
        next_wd    = head_cur;
        unique case (req_reg)
            REQ_ALLOC:
            begin
                succ = (obj_reg != '0) && (head_cur != '0);
                if (succ)
                begin
                    obj_we     = 1'b1;
                    gen_we     = fresh;
                    live_new   = live_cur + 1'b1;
                    res_handle = (WORD_W'(alloc_gen) << INDEX_BITS) | WORD_W'(head_cur);
                    head_next[dom_reg] = fresh ? fresh_next : rd_next_reg;
                    if (fresh)
                    begin
                        fill_next[dom_reg] = head_inc;
                    end
                end
            end
            REQ_GET:
            begin
                succ = slot_ok;
                if (succ)
                begin
                    res_object = rd_obj_reg;
                end
            end
            REQ_TAKE:
            begin
                succ = slot_ok;
                if (succ)
                begin
                    res_object = rd_obj_reg;
                    obj_we     = 1'b1;
                    obj_wd     = '0;
                    gen_we     = 1'b1;
                    gen_wd     = rd_gen_reg + 1'b1;
                    next_we    = 1'b1;
                    head_next[dom_reg] = idx_reg;
                    if (live_cur != '0)
                    begin
                        live_new = live_cur - 1'b1;
                    end
                end
            end
            REQ_REPLACE:
            begin
                succ = slot_ok && (obj_reg != '0);
                obj_we = succ;
            end
            default:
            begin
                succ = 1'b0;
            end
        endcase
        if (!dom_ok_reg)
        begin
            succ       = 1'b0;
            res_handle = '0;
            res_object = '0;
            obj_we     = 1'b0;
            gen_we     = 1'b0;
            next_we    = 1'b0;
            head_next  = head_reg;
            fill_next  = fill_reg;
            live_new   = live_cur;
        end
        live_next[dom_reg] = live_new;
        if (live_new > peak_cur)
        begin
            peak_next[dom_reg] = live_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && obj_we)
        begin
            obj_mem[addr_reg] <= obj_wd;
        end
        if (cmd.issue)
        begin
            rd_obj_reg <= obj_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && gen_we)
        begin
            gen_mem[addr_reg] <= gen_wd;
        end
        if (cmd.issue)
        begin
            rd_gen_reg <= gen_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && next_we)
        begin
            next_mem[addr_reg] <= next_wd;
        end
        if (cmd.issue)
        begin
            rd_next_reg <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DOMAINS; d++)
            begin
                head_reg[d] <= IW'(1);
                fill_reg[d] <= (IW+1)'(1);
                live_reg[d] <= '0;
                peak_reg[d] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            live_reg <= live_next;
            peak_reg <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            ok_reg         <= succ;
            out_handle_reg <= res_handle;
            out_object_reg <= res_object;
            live_count_reg <= dom_ok_reg ? sat_count(32'(live_next[dom_reg])) : '0;
            peak_count_reg <= dom_ok_reg ? sat_count(32'(peak_next[dom_reg])) : '0;
        end
    end

    assign ok         = ok_reg;
    assign out_handle = out_handle_reg;
    assign out_object = out_object_reg;
    assign live_count = live_count_reg;
    assign peak_count = peak_count_reg;

endmodule

FILE: design/generational_handle_table_core.sv
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                                tuser
// s_axis    in   domain 4, handle 32, object 32, pad 4             req_type 2
// m_axis    out  out_handle 32, out_object 32, live 8, peak 8      ok 1
//
// A request is accepted with the slot memory read, then the execute state does the
// read-modify-write of the slot memories and the domain counters.
// s_tready is high only in the idle state, so no request is accepted while one executes.
// A full result register stalls the execute cycle until m_tready takes it.
// Reset clears the domain counters at once; no memory clearing pass is needed.

`include "generational_handle_table_core_macros.svh"

module generational_handle_table_core
#(
    parameter int DOMAINS    = ght_pkg::DOMAINS_DEF,
    parameter int SLOTS      = ght_pkg::SLOTS_DEF,
    parameter int INDEX_BITS = ght_pkg::INDEX_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // domain[3:0], handle[35:4], object[67:36], zero[71:68]
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // out_handle[31:0], out_object[63:32], live[71:64], peak[79:72]
    output logic [0:0]  m_tuser   // ok[0]
);
    import ght_pkg::*;

    ght_cmd_t           cmd;
    logic               ok;
    logic [WORD_W-1:0]  out_handle;
    logic [WORD_W-1:0]  out_object;
    logic [COUNT_W-1:0] live_count;
    logic [COUNT_W-1:0] peak_count;

    ght_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ght_dp
    #(
        .DOMAINS    (DOMAINS),
        .SLOTS      (SLOTS),
        .INDEX_BITS (INDEX_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (s_tuser),
        .domain     (s_tdata[3:0]),
        .handle     (s_tdata[35:4]),
        .object     (s_tdata[67:36]),
        .ok         (ok),
        .out_handle (out_handle),
        .out_object (out_object),
        .live_count (live_count),
        .peak_count (peak_count)
    );

    assign m_tdata = {peak_count, live_count, out_object, out_handle};
    assign m_tuser = ok;

    `GHT_ASSERT_NOW(a_no_overlap, cmd.issue, !cmd.commit, "issue and commit in one cycle")
    `GHT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accept while busy")
    `GHT_ASSERT_NEXT(a_commit_shows, cmd.commit, m_tvalid, "committed request not presented")
    `GHT_ASSERT_NOW(a_commit_free, cmd.commit && m_tvalid, m_tready, "result overwritten")

endmodule

FILE: tb/sv/generational_handle_table_core_test.sv
`timescale 1ns / 1ps

module generational_handle_table_core_test;
    import ght_pkg::*;

    localparam int DOMS   = DOMAINS_DEF;
    localparam int NSLOTS = SLOTS_DEF;
    localparam int IDXW   = INDEX_BITS_DEF;

    typedef struct {
        ght_req_t    kind;
        logic [3:0]  domain;
        logic [31:0] handle;
        logic [31:0] object;
    } request_t;

    typedef struct {
        logic        ok;
        logic [31:0] handle;
        logic [31:0] object;
        logic [7:0]  live;
        logic [7:0]  peak;
    } result_t;

    typedef enum {
        PH_MIXED,
        PH_FILL,
        PH_DRAIN,
        PH_CHURN
    } phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [0:0]  m_tuser;

    logic        steady = 1'b0;
    int          mismatches = 0;

    request_t    pending[$];
    request_t    cur;
    result_t     due_results[$];

    logic [31:0] slot_obj  [DOMS*NSLOTS];
    logic [7:0]  slot_gen  [DOMS*NSLOTS];
    int unsigned slot_link [DOMS*NSLOTS];
    int unsigned free_top  [DOMS];
    int unsigned live_n    [DOMS];
    int unsigned peak_n    [DOMS];
    int unsigned held      [DOMS][$];
    logic [31:0] retired[$];

    generational_handle_table_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic flag(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns: %s", $time, msg);
    endtask

    function automatic void clear_table();
        for (int d = 0; d < DOMS; d++)
        begin
            for (int i = 0; i < NSLOTS; i++)
            begin
                slot_obj[d*NSLOTS+i]  = '0;
                slot_gen[d*NSLOTS+i]  = '0;
                slot_link[d*NSLOTS+i] = (i + 1 < NSLOTS) ? i + 1 : 0;
            end
            free_top[d] = 1;
            live_n[d]   = 0;
            peak_n[d]   = 0;
            held[d].delete();
        end
        retired.delete();
    endfunction

    function automatic void serve_request(input request_t r, output result_t res);
        int unsigned base;
        int unsigned idx;
        int unsigned pos;
        int unsigned d;
        logic        hit;
        res = '{default: '0};
        d = 32'(r.domain);
        if (d < DOMS)
        begin
            base = d * NSLOTS;
            if (r.kind == REQ_ALLOC)
            begin
                idx = free_top[d];
                if (r.object != 0 && idx != 0 && idx < NSLOTS)
                begin
                    pos = base + idx;
                    free_top[d]    = slot_link[pos];
                    slot_link[pos] = 0;
                    slot_obj[pos]  = r.object;
                    live_n[d]++;
                    if (live_n[d] > peak_n[d])
                        peak_n[d] = live_n[d];
                    res.handle = (32'(slot_gen[pos]) << IDXW) | idx;
                    res.ok     = 1'b1;
                    held[d].push_back(idx);
                end
            end
            else
            begin
                idx = r.handle & 32'((1 << IDXW) - 1);
                pos = base + idx;
                hit = r.handle != 0 && idx != 0 && idx < NSLOTS;
                if (hit)
                    hit = slot_obj[pos] != 0 && slot_gen[pos] == 8'(r.handle >> IDXW);
                if (hit)
                begin
                    case (r.kind)
                        REQ_GET:
                        begin
                            res.object = slot_obj[pos];
                            res.ok     = 1'b1;
                        end
                        REQ_TAKE:
                        begin
                            res.object     = slot_obj[pos];
                            slot_obj[pos]  = '0;
                            slot_gen[pos]  = slot_gen[pos] + 8'd1;
                            slot_link[pos] = free_top[d];
                            free_top[d]    = idx;
                            if (live_n[d] > 0)
                                live_n[d]--;
                            res.ok = 1'b1;
                            for (int k = 0; k < held[d].size(); k++)
                            begin
                                if (held[d][k] == idx)
                                begin
                                    held[d].delete(k);
                                    break;
                                end
                            end
                            retired.push_back(r.handle);
                            if (retired.size() > 64)
                                void'(retired.pop_front());
                        end
                        default:
                        begin
                            if (r.object != 0)
                            begin
                                slot_obj[pos] = r.object;
                                res.ok = 1'b1;
                            end
                        end
                    endcase
                end
            end
            res.live = (live_n[d] > 255) ? 8'hFF : 8'(live_n[d]);
            res.peak = (peak_n[d] > 255) ? 8'hFF : 8'(peak_n[d]);
        end
    endfunction

    function automatic request_t mk(input ght_req_t k, input logic [3:0] d,
                                    input logic [31:0] h, input logic [31:0] o);
        request_t r;
        r.kind   = k;
        r.domain = d;
        r.handle = h;
        r.object = o;
        return r;
    endfunction

    function automatic logic [31:0] held_handle(input int d);
        int          n;
        int unsigned idx;
        n = held[d].size();
        if (n == 0 || $urandom_range(0, 99) < 12)
            return (retired.size() > 0) ? retired[$urandom_range(0, retired.size() - 1)]
                                        : $urandom;
        idx = held[d][$urandom_range(0, n - 1)];
        return (32'(slot_gen[d*NSLOTS+idx]) << IDXW) | idx;
    endfunction

    function automatic request_t make_request(input phase_t ph, input int hot);
        request_t    r;
        int          d;
        int          roll;
        int unsigned idx;
        roll = $urandom_range(0, 99);
        if (roll < ((ph == PH_CHURN) ? 4 : 10))
        begin
            r.kind   = ght_req_t'($urandom_range(0, 3));
            r.domain = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 4))
                0: r.handle = $urandom;
                1: r.handle = '0;
                2: r.handle = 32'($urandom_range(0, 255)) << IDXW;
                3: r.handle = (32'($urandom_range(0, 255)) << IDXW)
                              | $urandom_range(NSLOTS, (1 << IDXW) - 1);
                default: r.handle = held_handle(r.domain % DOMS)
                                    ^ (32'(1) << (IDXW + $urandom_range(0, 7)));
            endcase
            r.object = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
            return r;
        end
        d = (ph == PH_CHURN || $urandom_range(0, 99) < 80) ? hot : $urandom_range(0, DOMS - 1);
        r.domain = 4'(d);
        r.object = $urandom;
        if (r.object == 0)
            r.object = 1;
        r.handle = held_handle(d);
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
                r.kind = (roll < 85) ? REQ_ALLOC : ght_req_t'($urandom_range(1, 3));
            PH_DRAIN:
                r.kind = (roll < 70) ? REQ_TAKE : (roll < 80) ? REQ_ALLOC :
                         (roll < 90) ? REQ_GET : REQ_REPLACE;
            PH_CHURN:
            begin
                if (held[d].size() == 0)
                    r.kind = REQ_ALLOC;
                else
                begin
                    idx      = held[d][$];
                    r.kind   = REQ_TAKE;
                    r.handle = (32'(slot_gen[d*NSLOTS+idx]) << IDXW) | idx;
                end
            end
            default:
                r.kind = ght_req_t'($urandom_range(0, 3));
        endcase
        return r;
    endfunction

    // request side
    always @(posedge clk or negedge rst_n)
    begin
        result_t res;
        logic    load;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            clear_table();
        end
        else
        begin
            load = 1'b0;
            if (s_tvalid && s_tready)
            begin
                serve_request(cur, res);
                due_results.push_back(res);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending.size() > 0 && (steady || $urandom_range(0, 99) >= 10))
                begin
                    cur  = pending.pop_front();
                    load = 1'b1;
                end
            end
            if (load)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, cur.object, cur.handle, cur.domain};
                s_tuser  <= cur.kind;
            end
            else if (!s_tvalid || s_tready)
                s_tvalid <= 1'b0;
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                    flag("result with no request outstanding");
                else
                begin
                    want = due_results.pop_front();
                    if (m_tuser[0] !== want.ok)
                        flag($sformatf("ok got %b want %b", m_tuser[0], want.ok));
                    if (m_tdata[31:0] !== want.handle)
                        flag($sformatf("out_handle got %h want %h", m_tdata[31:0], want.handle));
                    if (m_tdata[63:32] !== want.object)
                        flag($sformatf("out_object got %h want %h", m_tdata[63:32], want.object));
                    if (m_tdata[71:64] !== want.live)
                        flag($sformatf("live_count got %0d want %0d", m_tdata[71:64], want.live));
                    if (m_tdata[79:72] !== want.peak)
                        flag($sformatf("peak_count got %0d want %0d", m_tdata[79:72], want.peak));
                end
            end
            m_tready <= steady || $urandom_range(0, 99) >= 10;
        end
    end

    task automatic settle();
        while (pending.size() != 0 || s_tvalid || due_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input phase_t ph, input int hot, input int count);
        for (int n = 0; n < count; n++)
        begin
            while (pending.size() >= 2
                   || (ph == PH_CHURN && (pending.size() != 0 || s_tvalid)))
                @(negedge clk);
            pending.push_back(make_request(ph, hot));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending.push_back(mk(REQ_GET,     4'd0,  32'h0000_0000, 32'h0000_0000));
        pending.push_back(mk(REQ_ALLOC,   4'd0,  32'h0000_0000, 32'hFFFF_FFFF));
        pending.push_back(mk(REQ_ALLOC,   4'd0,  32'h0000_0000, 32'h0000_0000));
        pending.push_back(mk(REQ_ALLOC,   4'd0,  32'hFFFF_FFFF, 32'h0000_0001));
        pending.push_back(mk(REQ_GET,     4'd0,  32'h0000_0001, 32'h0000_0000));
        pending.push_back(mk(REQ_GET,     4'd0,  32'h0100_0001, 32'h0000_0000));
        pending.push_back(mk(REQ_GET,     4'd0,  32'h0000_0100, 32'h0000_0000));
        pending.push_back(mk(REQ_GET,     4'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending.push_back(mk(REQ_GET,     4'd0,  32'h0500_0000, 32'h0000_0000));
        pending.push_back(mk(REQ_REPLACE, 4'd0,  32'h0000_0001, 32'h1234_5678));
        pending.push_back(mk(REQ_REPLACE, 4'd0,  32'h0000_0001, 32'h0000_0000));
        pending.push_back(mk(REQ_TAKE,    4'd0,  32'h0000_0001, 32'h0000_0000));
        pending.push_back(mk(REQ_TAKE,    4'd0,  32'h0000_0001, 32'h0000_0000));
        pending.push_back(mk(REQ_GET,     4'd0,  32'h0100_0001, 32'h0000_0000));
        pending.push_back(mk(REQ_ALLOC,   4'd0,  32'h0000_0000, 32'hA5A5_A5A5));
        pending.push_back(mk(REQ_GET,     4'd0,  32'h0100_0001, 32'h0000_0000));
        pending.push_back(mk(REQ_REPLACE, 4'd0,  32'h0000_0003, 32'h0000_0007));
        pending.push_back(mk(REQ_ALLOC,   4'd7,  32'h0000_0000, 32'h8000_0000));
        pending.push_back(mk(REQ_ALLOC,   4'd8,  32'h0000_0000, 32'h0000_0010));
        pending.push_back(mk(REQ_GET,     4'd15, 32'h0000_0001, 32'h0000_0000));
        pending.push_back(mk(REQ_TAKE,    4'd0,  32'h0000_0002, 32'h0000_0000));
        pending.push_back(mk(REQ_TAKE,    4'd0,  32'h0100_0001, 32'h5A5A_5A5A));
        settle();

        run_phase(PH_MIXED, 3, 120);
        settle();
        steady = 1'b1;
        run_phase(PH_FILL, 5, 460);
        settle();
        steady = 1'b0;
        run_phase(PH_DRAIN, 5, 280);
        settle();
        run_phase(PH_CHURN, 6, 600);
        settle();
        run_phase(PH_MIXED, 1, 80);
        settle();

        repeat (20) @(posedge clk);
        if (due_results.size() != 0)
            flag($sformatf("%0d results never arrived", due_results.size()));
        if (mismatches == 0)
            $display("** generational_handle_table_core: PASSED **");
        else
            $display("** generational_handle_table_core: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout");
        $display("** generational_handle_table_core: FAILED **");
        $finish;
    end

endmodule
